// ===== sv/spr_pkg.sv =====
// spr_pkg: shared widths, field offsets and controller/datapath handshake types
// for the speed profile resampler; no dependencies
`default_nettype none

package spr_pkg;

  // knot field widths
  localparam int unsigned POS_W  = 24;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned LANES  = 3;
  localparam int unsigned LN_W   = 2;
  localparam int unsigned QUO_W  = 16;
  localparam int unsigned DC_W   = 4;
  localparam int unsigned PROD_W = POS_W + VAL_W;

  // ram word layout, lowest bit up: position, speed, accel, time
  localparam int unsigned WORD_W   = POS_W + 3 * VAL_W;
  localparam int unsigned W_POS_LO = 0;
  localparam int unsigned W_SPD_LO = POS_W;
  localparam int unsigned W_ACC_LO = POS_W + VAL_W;
  localparam int unsigned W_TIM_LO = POS_W + 2 * VAL_W;

  // input tdata layout, lowest bit up
  localparam int unsigned IN_IDX_LO = 0;
  localparam int unsigned IN_POS_LO = IN_IDX_LO + IDX_W;
  localparam int unsigned IN_SPD_LO = IN_POS_LO + POS_W;
  localparam int unsigned IN_ACC_LO = IN_SPD_LO + VAL_W;
  localparam int unsigned IN_TIM_LO = IN_ACC_LO + VAL_W;
  localparam int unsigned IN_QRY_LO = IN_TIM_LO + VAL_W;
  localparam int unsigned IN_USED_W = IN_QRY_LO + POS_W;
  localparam int unsigned IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

  // output tdata: speed, accel, time
  localparam int unsigned OUT_DATA_W = 3 * VAL_W;

  // tuser action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic wr;        // write beat accepted
    logic init;      // query beat accepted
    logic srch;      // one search step
    logic sel;       // pick neighbour or clamp entry
    logic ld_a;      // latch lower neighbour
    logic ld_b;      // latch upper neighbour, form deltas
    logic ld_k;      // latch clamp entry
    logic mul;       // one lane product
    logic div;       // one quotient bit on all lanes
    logic load_out;  // load result register
  } cmd_t;

  typedef struct packed {
    logic n_zero;     // no knots in use
    logic srch_done;  // search range empty after this step
    logic edge_hit;   // query at or below first or beyond last knot
    logic mul_last;   // last lane product
    logic div_last;   // last quotient bit
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/spr_ram.sv =====
// spr_ram: generic one-write one-read ram with registered read data
// no dependencies
`default_nettype none

module spr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/spr_ctrl.sv =====
// spr_ctrl: sequencing state machine of the resampler
// depends on spr_pkg for the command and status types
`default_nettype none

module spr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_action_i,
  output      logic          in_ready_o,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      spr_pkg::cmd_t cmd_o,
  input  wire spr_pkg::sts_t sts_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SRCH = 4'd1;
  localparam logic [3:0] ST_SEL  = 4'd2;
  localparam logic [3:0] ST_RDB  = 4'd3;
  localparam logic [3:0] ST_LDB  = 4'd4;
  localparam logic [3:0] ST_LDK  = 4'd5;
  localparam logic [3:0] ST_MUL  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_action_i == spr_pkg::ACT_WRITE)) begin
          cmd_o.wr = 1'b1;
        end else if (accept) begin
          cmd_o.init = 1'b1;
          state_d    = sts_i.n_zero ? ST_FIN : ST_SRCH;
        end
      end
      ST_SRCH: begin
        cmd_o.srch = 1'b1;
        if (sts_i.srch_done) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = sts_i.edge_hit ? ST_LDK : ST_RDB;
      end
      ST_RDB: begin
        cmd_o.ld_a = 1'b1;
        state_d    = ST_LDB;
      end
      ST_LDB: begin
        cmd_o.ld_b = 1'b1;
        state_d    = ST_MUL;
      end
      ST_LDK: begin
        cmd_o.ld_k = 1'b1;
        state_d    = ST_FIN;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        if (sts_i.mul_last) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/spr_dpath.sv =====
// spr_dpath: knot table, search registers, lane multiplier and dividers
// depends on spr_pkg and spr_ram
`default_nettype none

module spr_dpath #(
  parameter int unsigned MAX_KNOTS = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire spr_pkg::cmd_t                  cmd_i,
  output      spr_pkg::sts_t                  sts_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [spr_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic [spr_pkg::IN_DATA_W-1:0]  in_data_i,
  output      logic [spr_pkg::OUT_DATA_W-1:0] out_data_o,
  output      logic                           out_empty_o
);

  localparam int unsigned AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_KNOTS + 1);
  localparam int unsigned VW = spr_pkg::VAL_W + 1;

  // configuration register
  logic [spr_pkg::CFG_W-1:0] knots_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knots_q <= '0;
    end else if (cfg_we_i) begin
      knots_q <= cfg_wdata_i;
    end
  end

  // clamp knots in use to the table depth
  logic [31:0]   n_w;
  logic [CW-1:0] n_d;

  assign n_w = (32'(knots_q) > 32'(MAX_KNOTS)) ? 32'(MAX_KNOTS) : 32'(knots_q);
  assign n_d = n_w[CW-1:0];

  // input fields
  logic [spr_pkg::IDX_W-1:0] in_idx;
  logic [spr_pkg::POS_W-1:0] in_pos, in_qry;
  logic [spr_pkg::VAL_W-1:0] in_spd, in_acc, in_tim;
  logic [31:0]               idx_w;

  assign in_idx = in_data_i[spr_pkg::IN_IDX_LO +: spr_pkg::IDX_W];
  assign in_pos = in_data_i[spr_pkg::IN_POS_LO +: spr_pkg::POS_W];
  assign in_spd = in_data_i[spr_pkg::IN_SPD_LO +: spr_pkg::VAL_W];
  assign in_acc = in_data_i[spr_pkg::IN_ACC_LO +: spr_pkg::VAL_W];
  assign in_tim = in_data_i[spr_pkg::IN_TIM_LO +: spr_pkg::VAL_W];
  assign in_qry = in_data_i[spr_pkg::IN_QRY_LO +: spr_pkg::POS_W];
  assign idx_w  = 32'(in_idx);

  // knot table
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [spr_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  assign ram_we    = cmd_i.wr && (idx_w < 32'(MAX_KNOTS));
  assign ram_waddr = idx_w[AW-1:0];
  assign ram_wdata = {in_tim, in_acc, in_spd, in_pos};

  spr_ram #(
    .WIDTH (spr_pkg::WORD_W),
    .DEPTH (MAX_KNOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [spr_pkg::POS_W-1:0] rd_pos;
  logic [VW-1:0]             rd_val [spr_pkg::LANES];

  assign rd_pos    = ram_rdata[spr_pkg::W_POS_LO +: spr_pkg::POS_W];
  assign rd_val[0] = {ram_rdata[spr_pkg::W_SPD_LO + spr_pkg::VAL_W - 1],
                      ram_rdata[spr_pkg::W_SPD_LO +: spr_pkg::VAL_W]};
  assign rd_val[1] = {ram_rdata[spr_pkg::W_ACC_LO + spr_pkg::VAL_W - 1],
                      ram_rdata[spr_pkg::W_ACC_LO +: spr_pkg::VAL_W]};
  assign rd_val[2] = {1'b0, ram_rdata[spr_pkg::W_TIM_LO +: spr_pkg::VAL_W]};

  // search registers
  logic [spr_pkg::POS_W-1:0] q_q;
  logic [CW-1:0]             n_q, lo_q, cnt_q;
  logic [AW-1:0]             it_q;
  logic                      empty_q;

  logic          lt;
  logic [CW-1:0] step, lo_n, cnt_n, probe;
  logic [AW-1:0] srch_addr, sel_addr;

  assign lt        = rd_pos < q_q;
  assign step      = cnt_q >> 1;
  assign lo_n      = lt ? (CW'(it_q) + CW'(1)) : lo_q;
  assign cnt_n     = lt ? (cnt_q - step - CW'(1)) : step;
  assign probe     = lo_n + (cnt_n >> 1);
  assign srch_addr = probe[AW-1:0];
  assign sel_addr  = (lo_q == '0) ? '0 : AW'(lo_q - CW'(1));

  always_comb begin
    if (cmd_i.srch) begin
      ram_raddr = srch_addr;
    end else if (cmd_i.sel) begin
      ram_raddr = sel_addr;
    end else if (cmd_i.ld_a) begin
      ram_raddr = AW'(lo_q);
    end else begin
      ram_raddr = AW'(n_d >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      q_q     <= in_qry;
      n_q     <= n_d;
      lo_q    <= '0;
      cnt_q   <= n_d;
      it_q    <= AW'(n_d >> 1);
      empty_q <= (n_d == '0);
    end else if (cmd_i.srch) begin
      lo_q  <= lo_n;
      cnt_q <= cnt_n;
      it_q  <= srch_addr;
    end
  end

  // interpolation lanes
  logic [spr_pkg::POS_W-1:0] p0_q, d_q, t_q;
  logic [VW-1:0]             v0_q  [spr_pkg::LANES];
  logic [spr_pkg::VAL_W-1:0] mag_q [spr_pkg::LANES];
  logic                      neg_q [spr_pkg::LANES];
  logic [spr_pkg::POS_W-1:0] rem_q [spr_pkg::LANES];
  logic [spr_pkg::QUO_W-1:0] sh_q  [spr_pkg::LANES];
  logic [spr_pkg::LN_W-1:0]  ln_q;
  logic [spr_pkg::DC_W-1:0]  dc_q;

  logic [VW-1:0]              delta [spr_pkg::LANES];
  logic [VW-1:0]              mag_w [spr_pkg::LANES];
  logic [spr_pkg::POS_W:0]    r2    [spr_pkg::LANES];
  logic                       ge    [spr_pkg::LANES];
  logic [spr_pkg::POS_W:0]    r2_sub[spr_pkg::LANES];
  logic [VW-1:0]              res   [spr_pkg::LANES];
  logic [VW-1:0]              quo_w [spr_pkg::LANES];
  logic [spr_pkg::VAL_W-1:0]  mul_a;
  logic [spr_pkg::PROD_W-1:0] prod;

  always_comb begin
    for (int l = 0; l < spr_pkg::LANES; l++) begin
      delta[l]  = rd_val[l] - v0_q[l];
      mag_w[l]  = delta[l][VW-1] ? (~delta[l] + VW'(1)) : delta[l];
      r2[l]     = {rem_q[l], sh_q[l][spr_pkg::QUO_W-1]};
      ge[l]     = r2[l] >= {1'b0, d_q};
      r2_sub[l] = r2[l] - {1'b0, d_q};
      quo_w[l]  = {1'b0, sh_q[l]};
      res[l]    = v0_q[l] + (neg_q[l] ? (~quo_w[l] + VW'(1)) : quo_w[l]);
    end
  end

  // one shared multiplier, one lane per cycle
  always_comb begin
    case (ln_q)
      2'd0:    mul_a = mag_q[0];
      2'd1:    mul_a = mag_q[1];
      default: mul_a = mag_q[2];
    endcase
  end

  assign prod = (spr_pkg::PROD_W'(mul_a) * spr_pkg::PROD_W'(t_q))
              + spr_pkg::PROD_W'(d_q >> 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) begin
      p0_q <= rd_pos;
      for (int l = 0; l < spr_pkg::LANES; l++) begin
        v0_q[l] <= rd_val[l];
      end
    end
    if (cmd_i.ld_b) begin
      d_q  <= rd_pos - p0_q;
      t_q  <= q_q - p0_q;
      ln_q <= '0;
      dc_q <= '0;
      for (int l = 0; l < spr_pkg::LANES; l++) begin
        mag_q[l] <= mag_w[l][spr_pkg::VAL_W-1:0];
        neg_q[l] <= delta[l][VW-1];
      end
    end
    if (cmd_i.ld_k) begin
      for (int l = 0; l < spr_pkg::LANES; l++) begin
        v0_q[l]  <= rd_val[l];
        neg_q[l] <= 1'b0;
        sh_q[l]  <= '0;
      end
    end
    if (cmd_i.mul) begin
      ln_q <= ln_q + spr_pkg::LN_W'(1);
      for (int l = 0; l < spr_pkg::LANES; l++) begin
        if (ln_q == spr_pkg::LN_W'(l)) begin
          rem_q[l] <= prod[spr_pkg::PROD_W-1:spr_pkg::QUO_W];
          sh_q[l]  <= prod[spr_pkg::QUO_W-1:0];
        end
      end
    end
    if (cmd_i.div) begin
      dc_q <= dc_q + spr_pkg::DC_W'(1);
      for (int l = 0; l < spr_pkg::LANES; l++) begin
        rem_q[l] <= ge[l] ? r2_sub[l][spr_pkg::POS_W-1:0] : r2[l][spr_pkg::POS_W-1:0];
        sh_q[l]  <= {sh_q[l][spr_pkg::QUO_W-2:0], ge[l]};
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_empty_o <= empty_q;
      if (empty_q) begin
        out_data_o <= '0;
      end else begin
        out_data_o <= {res[2][spr_pkg::VAL_W-1:0], res[1][spr_pkg::VAL_W-1:0],
                       res[0][spr_pkg::VAL_W-1:0]};
      end
    end
  end

  assign sts_o.n_zero    = (n_d == '0);
  assign sts_o.srch_done = (cnt_n == '0);
  assign sts_o.edge_hit  = (lo_q == '0) || (lo_q >= n_q);
  assign sts_o.mul_last  = (ln_q == spr_pkg::LN_W'(spr_pkg::LANES - 1));
  assign sts_o.div_last  = (dc_q == spr_pkg::DC_W'(spr_pkg::QUO_W - 1));

endmodule

`default_nettype wire

// ===== sv/speed_profile_resampler_top.sv =====
// speed_profile_resampler_top: stream wrapper of the speed profile resampler
// depends on spr_pkg, spr_ctrl, spr_dpath (and spr_ram below it)
//
// Holds a table of up to MAX_KNOTS speed-profile knots (position, speed,
// accel, time) in one ram and answers position queries by a halving search
// for the first knot not below the query, followed by linear interpolation
// with round-to-nearest. A write beat (tuser low) stores one knot; the block
// stays ready. A query beat (tuser high) on an empty table goes straight to
// the result register; a query that clamps to the first or last knot runs
// the search and loads the clamp entry; an interpolated query runs the
// search one step at a time on the single ram read port, forms the three
// lane products in turn on the shared lane multiplier and then runs
// bit-serial division on all three lanes at once. The result sits in an
// output register, so a write beat can be taken while a finished result
// waits. knots_in_use is to be written by the user only while idle; the
// block itself does not enforce it. The table is not cleared at reset;
// entries must be written before they are searched.
`default_nettype none

module speed_profile_resampler_top #(
  parameter int unsigned MAX_KNOTS = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration: knots_in_use
  input  wire logic                           cfg_we_i,
  input  wire logic [spr_pkg::CFG_W-1:0]      cfg_wdata_i,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // tdata: knot_index, knot_position, knot_speed, knot_accel, knot_time,
  //        query_position, zero pad
  input  wire logic [spr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action (0 write, 1 query)
  input  wire logic                           s_axis_tuser,
  // result stream
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: speed_out, accel_out, time_out
  output      logic [spr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: table_empty
  output      logic                           m_axis_tuser
);

  spr_pkg::cmd_t cmd;
  spr_pkg::sts_t sts;

  // sequencer: handshakes and state
  spr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // table, search and interpolation datapath
  spr_dpath #(
    .MAX_KNOTS (MAX_KNOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata),
    .out_empty_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== sv/spr_chk.sv =====
// spr_chk: port-level checker for the speed profile resampler, bound to top
// depends on spr_pkg and speed_profile_resampler_top
`default_nettype none

module spr_chk (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [spr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                           m_axis_tuser
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)))
    else $error("result beat changed while stalled");

  // a query beat starts work, input side closes
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
    else $error("ready stayed high after a query beat");

  // a knot write finishes in the cycle it is taken
  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> s_axis_tready)
    else $error("ready dropped after a write beat");

  // empty-table answers carry zero values
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("empty-table result with nonzero values");

  // a fresh result only appears at the end of query work
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without query work");

endmodule

bind speed_profile_resampler_top spr_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== bench/spr_checker.sv =====
// spr_checker: watches the config port and both streams of the speed profile
// resampler, keeps its own knot table and compares every result beat
// depends on spr_pkg
`default_nettype none

module spr_checker #(
  parameter int unsigned MAX_KNOTS = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [spr_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  input  wire logic                           s_axis_tready,
  input  wire logic [spr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                           s_axis_tuser,
  input  wire logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic [spr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                           m_axis_tuser,
  output int unsigned                         mismatch_count,
  output int unsigned                         samples_owed
);
  import spr_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] qpos;
    logic [VAL_W-1:0] speed;
    logic [VAL_W-1:0] accel;
    logic [VAL_W-1:0] stamp;
    logic             empty;
  } sample_t;

  logic [POS_W-1:0]        pos_tab   [MAX_KNOTS];
  logic signed [VAL_W-1:0] speed_tab [MAX_KNOTS];
  logic signed [VAL_W-1:0] accel_tab [MAX_KNOTS];
  logic [VAL_W-1:0]        stamp_tab [MAX_KNOTS];
  logic [CFG_W-1:0]        knot_count;
  sample_t                 pending_samples [$];
  sample_t                 want_s;
  sample_t                 got_s;
  logic [IDX_W-1:0]        wr_idx;

  // v0 + (v1 - v0) * t / d, quotient rounded to nearest, ties away from zero
  function automatic logic [VAL_W-1:0] blend(input longint v0, input longint v1,
                                             input longint t, input longint d);
    longint delta;
    longint mag;
    longint step;
    longint r;
    delta = v1 - v0;
    mag   = (delta < 0) ? -delta : delta;
    step  = (mag * t + d / 2) / d;
    r     = (delta < 0) ? v0 - step : v0 + step;
    return r[VAL_W-1:0];
  endfunction

  // halving search for the first knot not below the query, then clamp or interpolate
  function automatic sample_t resample(input logic [POS_W-1:0] qpos);
    int unsigned n;
    int unsigned lo;
    int unsigned span;
    int unsigned half;
    int unsigned mid;
    int unsigned k;
    longint      t;
    longint      d;
    sample_t     s;
    s      = '0;
    s.qpos = qpos;
    n = (knot_count > MAX_KNOTS) ? MAX_KNOTS : int'(knot_count);
    if (n == 0) begin
      s.empty = 1'b1;
      return s;
    end
    lo   = 0;
    span = n;
    while (span > 0) begin
      half = span / 2;
      mid  = lo + half;
      if (pos_tab[mid] < qpos) begin
        lo   = mid + 1;
        span = span - half - 1;
      end else begin
        span = half;
      end
    end
    if (lo == 0 || lo >= n) begin
      k       = (lo == 0) ? 0 : n - 1;
      s.speed = speed_tab[k];
      s.accel = accel_tab[k];
      s.stamp = stamp_tab[k];
    end else begin
      d       = longint'(pos_tab[lo]) - longint'(pos_tab[lo-1]);
      t       = longint'(qpos) - longint'(pos_tab[lo-1]);
      s.speed = blend(longint'(speed_tab[lo-1]), longint'(speed_tab[lo]), t, d);
      s.accel = blend(longint'(accel_tab[lo-1]), longint'(accel_tab[lo]), t, d);
      s.stamp = blend(longint'(stamp_tab[lo-1]), longint'(stamp_tab[lo]), t, d);
    end
    return s;
  endfunction

  task automatic check_field(input string label, input logic [POS_W-1:0] qpos,
                             input logic [VAL_W-1:0] want, input logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, query at %h: expected %h, got %h",
               $time, label, qpos, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count = '0;
      pending_samples.delete();
      samples_owed <= 0;
    end else begin
      // result side first: a beat leaving now belongs to an older query
      if (m_axis_tvalid && m_axis_tready) begin
        got_s       = '0;
        got_s.speed = m_axis_tdata[0 +: VAL_W];
        got_s.accel = m_axis_tdata[VAL_W +: VAL_W];
        got_s.stamp = m_axis_tdata[2*VAL_W +: VAL_W];
        got_s.empty = m_axis_tuser;
        if (pending_samples.size() == 0) begin
          $display("%0t: result beat with no query waiting: speed %h accel %h time %h empty %b",
                   $time, got_s.speed, got_s.accel, got_s.stamp, got_s.empty);
          mismatch_count++;
        end else begin
          want_s = pending_samples.pop_front();
          check_field("speed", want_s.qpos, want_s.speed, got_s.speed);
          check_field("accel", want_s.qpos, want_s.accel, got_s.accel);
          check_field("time", want_s.qpos, want_s.stamp, got_s.stamp);
          check_field("table_empty", want_s.qpos, VAL_W'(want_s.empty), VAL_W'(got_s.empty));
        end
      end
      if (cfg_we_i) begin
        knot_count = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == ACT_WRITE) begin
          wr_idx = s_axis_tdata[IN_IDX_LO +: IDX_W];
          if (wr_idx < MAX_KNOTS) begin
            pos_tab[wr_idx]   = s_axis_tdata[IN_POS_LO +: POS_W];
            speed_tab[wr_idx] = s_axis_tdata[IN_SPD_LO +: VAL_W];
            accel_tab[wr_idx] = s_axis_tdata[IN_ACC_LO +: VAL_W];
            stamp_tab[wr_idx] = s_axis_tdata[IN_TIM_LO +: VAL_W];
          end
        end else begin
          pending_samples.insert(pending_samples.size(),
                                 resample(s_axis_tdata[IN_QRY_LO +: POS_W]));
        end
      end
      samples_owed <= pending_samples.size();
    end
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: drives knot writes, knots_in_use settings and position queries
// into speed_profile_resampler_top; spr_checker predicts and compares results
// depends on spr_pkg, speed_profile_resampler_top and spr_checker
`default_nettype none

module testbench;
  import spr_pkg::*;

  localparam int unsigned MAX_KNOTS     = 128;
  localparam int unsigned RANDOM_ITEMS  = 1900;
  // leave margin for the longest query and a trailing write
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT   = 50000;
  localparam logic [POS_W-1:0] POS_MAX  = '1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // tdata: knot_index, knot_position, knot_speed, knot_accel, knot_time,
  //        query_position, zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // tuser: action
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata: speed_out, accel_out, time_out
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // tuser: table_empty
  logic                  m_axis_tuser;

  int unsigned mismatch_count;
  int unsigned samples_owed;

  // idling percentages, changed between phases of the run
  int unsigned send_idle_pct = 20;
  int unsigned stall_pct     = 77;

  // stimulus-side copy of the knot positions, used to aim queries
  logic [POS_W-1:0] knot_pos [MAX_KNOTS];
  int unsigned      cur_knots;
  int unsigned      beats_sent;
  int unsigned      n_writes;
  int unsigned      n_queries;
  int unsigned      n_empty;
  int unsigned      n_settings;

  speed_profile_resampler_top #(
    .MAX_KNOTS(MAX_KNOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  spr_checker #(
    .MAX_KNOTS(MAX_KNOTS)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatch_count(mismatch_count),
    .samples_owed  (samples_owed)
  );

  // 10 unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // hard stop in case a handshake never completes
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d results still owed", $time, samples_owed);
    $display("Test completed with failures");
    $finish;
  end

  // mostly random values, with the signed and unsigned extremes mixed in
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // one input beat; fields the action does not use carry random bits
  task automatic push_beat(input logic act, input logic [IDX_W-1:0] idx,
                           input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] spd,
                           input logic [VAL_W-1:0] acc, input logic [VAL_W-1:0] tim,
                           input logic [POS_W-1:0] qpos);
    logic [IN_DATA_W-1:0] beat;
    beat = '0;
    beat[IN_IDX_LO +: IDX_W] = idx;
    beat[IN_POS_LO +: POS_W] = pos;
    beat[IN_SPD_LO +: VAL_W] = spd;
    beat[IN_ACC_LO +: VAL_W] = acc;
    beat[IN_TIM_LO +: VAL_W] = tim;
    beat[IN_QRY_LO +: POS_W] = qpos;
    // sender gaps; valid drops only here and in settle, so it never falls and rises in one step
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
    if (act == ACT_WRITE) begin
      knot_pos[idx] = pos;
      n_writes++;
    end else begin
      n_queries++;
      if (cur_knots == 0) n_empty++;
    end
  endtask

  task automatic write_knot(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] spd, input logic [VAL_W-1:0] acc,
                            input logic [VAL_W-1:0] tim);
    push_beat(ACT_WRITE, idx, pos, spd, acc, tim, POS_W'($urandom));
  endtask

  task automatic query_at(input logic [POS_W-1:0] qpos);
    push_beat(ACT_QUERY, IDX_W'($urandom), POS_W'($urandom), VAL_W'($urandom),
              VAL_W'($urandom), VAL_W'($urandom), qpos);
  endtask

  // drop valid, wait for every owed result, then let a trailing write finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    for (int unsigned w = 0; w < DRAIN_LIMIT && samples_owed != 0; w++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // knots_in_use may only change while the block is idle
  task automatic set_knot_count(input int unsigned setting);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(setting);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_knots  = setting;
    n_settings++;
  endtask

  initial begin
    int unsigned      first_random;
    int unsigned      phase;
    int unsigned      setting;
    int unsigned      used;
    int unsigned      fresh;
    int unsigned      start;
    int unsigned      gmax;
    int unsigned      p;
    int unsigned      k;
    bit               unsorted;
    logic [POS_W-1:0] q;

    // every input known from time zero, reset held low at the start
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_WRITE;
    cur_knots  = 0;
    beats_sent = 0;
    n_writes   = 0;
    n_queries  = 0;
    n_empty    = 0;
    n_settings = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---------------- directed part ----------------
    set_knot_count(0);

    // empty table: flag set, values zero
    query_at('0);
    query_at(POS_MAX);

    // four knots with extreme values; knots 0 and 1 share a position
    write_knot(0, 24'h000100, 16'h8000, 16'h7FFF, 16'h0000);
    write_knot(1, 24'h000100, 16'h7FFF, 16'h8000, 16'hFFFF);
    write_knot(2, 24'h800000, 16'h8000, 16'h7FFF, 16'h0000);
    write_knot(3, 24'hFFFFFE, 16'h0000, 16'hFFFF, 16'h1234);

    // single knot: clamps on both sides
    set_knot_count(1);
    query_at('0);
    query_at(POS_MAX);

    set_knot_count(4);
    query_at('0);            // below the first knot
    query_at(24'h000100);    // on the first knot
    query_at(24'h000101);    // just past a duplicate, full-scale speed swing
    query_at(24'h400080);    // mid segment
    query_at(24'h800000);    // on an inner knot
    query_at(24'hC00000);    // between the last two knots
    query_at(24'hFFFFFE);    // on the last knot
    query_at(POS_MAX);       // beyond the last knot

    // unsorted positions: search still lands on a valid pair
    write_knot(1, 24'h900000, 16'h1234, 16'hEDCB, 16'h4321);
    query_at(24'h850000);

    // exact half steps: rounding ties go away from zero, both signs
    write_knot(0, 24'h000010, 16'h0003, 16'hFFFD, 16'h0001);
    write_knot(1, 24'h000012, 16'h0004, 16'hFFFC, 16'h0002);
    set_knot_count(2);
    query_at(24'h000011);

    // ---------------- random part ----------------
    first_random = beats_sent;
    phase        = 0;
    while (beats_sent - first_random < RANDOM_ITEMS) begin
      // idling scheme follows progress through the random part
      if (beats_sent - first_random < RANDOM_ITEMS / 3) begin
        send_idle_pct = 20;
        stall_pct     = 77;
      end else if (beats_sent - first_random < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 77;
        stall_pct     = 20;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end

      // first a full table, then the oversized count; after that mostly small
      if (phase == 0) begin
        setting = MAX_KNOTS;
      end else if (phase == 1) begin
        setting = 255;
      end else begin
        case ($urandom_range(0, 19))
          0:           setting = 0;
          1, 2:        setting = $urandom_range(1, 2);
          3:           setting = $urandom_range(17, 64);
          4:           setting = $urandom_range(65, MAX_KNOTS);
          5:           setting = $urandom_range(MAX_KNOTS + 1, 255);
          default:     setting = $urandom_range(3, 16);
        endcase
      end
      phase++;

      // fresh knot table below the count; an oversized count reuses the full table
      fresh = (setting > MAX_KNOTS) ? 0 : setting;
      unsorted = ($urandom_range(0, 9) == 0);
      start = $urandom_range(0, 32'h00FF_FFFF) >> $urandom_range(0, POS_W);
      gmax  = (int'(POS_MAX) - start) / (fresh + 1);
      // tight spacing gives duplicates and short segments with rounding ties
      if ($urandom_range(0, 2) == 0 && gmax > 8) gmax = $urandom_range(0, 8);
      p = start;
      for (int unsigned i = 0; i < fresh; i++) begin
        if (unsorted) p = $urandom_range(0, 32'h00FF_FFFF);
        else if (i > 0) p = p + $urandom_range(0, gmax);
        write_knot(IDX_W'(i), POS_W'(p), pick_value(), pick_value(), pick_value());
      end

      set_knot_count(setting);
      used = (setting > MAX_KNOTS) ? MAX_KNOTS : setting;

      repeat ($urandom_range(8, 40)) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray rewrite anywhere in the table, may break the ordering
          write_knot(IDX_W'($urandom), POS_W'($urandom), pick_value(), pick_value(),
                     pick_value());
        end else begin
          if (used == 0) begin
            q = POS_W'($urandom);
          end else begin
            k = $urandom_range(0, used - 1);
            case ($urandom_range(0, 9))
              0: q = knot_pos[k];
              1: q = knot_pos[k] + 1'b1;
              2: q = knot_pos[k] - 1'b1;
              3, 4, 5: begin
                // inside a segment
                if (k > 0) q = POS_W'($urandom_range(knot_pos[k-1], knot_pos[k]));
                else q = knot_pos[k];
              end
              6: q = POS_W'($urandom_range(0, knot_pos[0]));
              7: q = POS_W'($urandom_range(POS_MAX, knot_pos[used-1]));
              default: q = POS_W'($urandom);
            endcase
          end
          query_at(q);
        end
      end
    end

    // ---------------- wind down ----------------
    settle();
    if (samples_owed != 0) begin
      $display("%0t: %0d expected results never arrived", $time, samples_owed);
    end
    $display("covered %0d knot writes and %0d queries (%0d on an empty table) over %0d knots_in_use settings",
             n_writes, n_queries, n_empty, n_settings);
    $display("back-pressure: sender 20%%/receiver 77%% idle, then swapped, then none");
    if (mismatch_count == 0 && samples_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
